/* src/ubjp_pkg.sv */
// Package for the UBJSON stream parser: constants, phase and event codes.
// Used by ubjson_stream_parser; depends on nothing.
`default_nettype none
package ubjp_pkg;
  localparam int MaxDepth = 32;
  localparam int CntW = $clog2(MaxDepth + 1);
  localparam int IdxW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

  typedef enum logic [2:0] {
    PhStart, PhFirstKey, PhKey, PhValue, PhNumber, PhStrMark, PhText, PhDone
  } phase_e;

  typedef enum logic [1:0] {
    KindInt, KindDbl, KindKeyLen, KindStrLen
  } kind_e;

  localparam logic [3:0] EvNone = 4'd0;
  localparam logic [3:0] EvObjOpen = 4'd1;
  localparam logic [3:0] EvObjClose = 4'd2;
  localparam logic [3:0] EvListOpen = 4'd3;
  localparam logic [3:0] EvListClose = 4'd4;
  localparam logic [3:0] EvNull = 4'd5;
  localparam logic [3:0] EvTrue = 4'd6;
  localparam logic [3:0] EvFalse = 4'd7;
  localparam logic [3:0] EvInt = 4'd8;
  localparam logic [3:0] EvDbl = 4'd9;
  localparam logic [3:0] EvKeyLen = 4'd10;
  localparam logic [3:0] EvKeyByte = 4'd11;
  localparam logic [3:0] EvStrLen = 4'd12;
  localparam logic [3:0] EvStrByte = 4'd13;

  localparam logic [1:0] StBusy = 2'd0;
  localparam logic [1:0] StOk = 2'd1;
  localparam logic [1:0] StErr = 2'd2;

  // Byte count of an integer marker, zero for anything else.
  function automatic logic [3:0] int_size(input logic [7:0] m);
    unique case (m)
      8'h69, 8'h55: int_size = 4'd1;
      8'h49: int_size = 4'd2;
      8'h6C: int_size = 4'd4;
      8'h4C: int_size = 4'd8;
      default: int_size = 4'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

/* src/ubjson_stream_parser.sv */
// UBJSON stream parser top level: one document byte in, one token word out.
// Depends on ubjp_pkg.
//
// Takes one byte per cycle and returns one token word per byte, registered
// and valid in the cycle after the byte is taken; a new byte is accepted every cycle while the output
// register is empty or being drained. Each byte touches only the top of
// the nesting stack, a flop array of ubjp_pkg::MaxDepth bits. Errors are
// sticky until a byte flagged as end of document, which also restarts the
// parser for the next document.
`default_nettype none
module ubjson_stream_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [7:0]  s_tdata_i,   // [7:0] in_byte
  input  wire logic        s_tlast_i,   // end_of_document
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [79:0]      m_tdata_o    // [3:0] event_res, [67:4] out_value,
                                        // [73:68] nest_depth, [75:74] status
);
  localparam int MD = ubjp_pkg::MaxDepth;
  localparam int CW = ubjp_pkg::CntW;
  localparam int IW = ubjp_pkg::IdxW;

  logic [MD-1:0] kinds_q, kinds_d;
  logic [CW-1:0] cnt_q, cnt_d;
  ubjp_pkg::phase_e ph_q, ph_d;
  logic pend_q, pend_d, sfirst_q, sfirst_d, err_q, err_d;
  logic [63:0] acc_q, acc_d, txt_q, txt_d;
  logic [3:0] nleft_q, nleft_d;
  ubjp_pkg::kind_e kind_q, kind_d;
  logic [3:0] ev;
  logic [63:0] val;
  logic [1:0] st;
  logic vld_q;
  logic [79:0] out_q;
  logic acc_in;
  logic [7:0] b;
  logic [3:0] isz, nl;
  logic [63:0] na;
  logic top_kind;

  assign s_tready_o = !vld_q || m_tready_i;
  assign acc_in = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = vld_q;
  assign m_tdata_o = out_q;
  assign b = s_tdata_i;
  assign isz = ubjp_pkg::int_size(b);

  always_comb begin
    kinds_d = kinds_q; cnt_d = cnt_q; ph_d = ph_q; pend_d = pend_q;
    sfirst_d = sfirst_q; err_d = err_q; acc_d = acc_q; txt_d = txt_q;
    nleft_d = nleft_q; kind_d = kind_q;
    ev = ubjp_pkg::EvNone; val = '0;
    top_kind = 1'b0;
    na = '0; nl = '0;
    if (!err_q) begin
      unique case (ph_q)
        ubjp_pkg::PhStart: begin
          if (b == 8'h7B) begin
            kinds_d[0] = 1'b0; cnt_d = CW'(1); ev = ubjp_pkg::EvObjOpen;
            ph_d = ubjp_pkg::PhFirstKey;
          end else err_d = 1'b1;
        end
        ubjp_pkg::PhFirstKey, ubjp_pkg::PhKey: begin
          if (isz != 4'd0) begin
            nleft_d = isz; kind_d = ubjp_pkg::KindKeyLen;
            sfirst_d = (b != 8'h55); acc_d = '0; ph_d = ubjp_pkg::PhNumber;
          end else if (b == 8'h7D && ph_q == ubjp_pkg::PhKey) begin
            cnt_d = cnt_q - CW'(1); ev = ubjp_pkg::EvObjClose;
          end else err_d = 1'b1;
        end
        ubjp_pkg::PhValue: begin
          if (b == 8'h5D && !pend_q) begin
            cnt_d = cnt_q - CW'(1); ev = ubjp_pkg::EvListClose;
          end else if (b == 8'h5A) ev = ubjp_pkg::EvNull;
          else if (b == 8'h54) ev = ubjp_pkg::EvTrue;
          else if (b == 8'h46) ev = ubjp_pkg::EvFalse;
          else if (isz != 4'd0) begin
            nleft_d = isz; kind_d = ubjp_pkg::KindInt;
            sfirst_d = (b != 8'h55); acc_d = '0; ph_d = ubjp_pkg::PhNumber;
          end else if (b == 8'h44) begin
            nleft_d = 4'd8; kind_d = ubjp_pkg::KindDbl;
            sfirst_d = 1'b1; acc_d = '0; ph_d = ubjp_pkg::PhNumber;
          end else if (b == 8'h53) ph_d = ubjp_pkg::PhStrMark;
          else if (b == 8'h7B || b == 8'h5B) begin
            if (cnt_q >= CW'(MD)) err_d = 1'b1;
            else begin
              kinds_d[cnt_q[IW-1:0]] = (b == 8'h5B);
              cnt_d = cnt_q + CW'(1); pend_d = 1'b0;
              ev = (b == 8'h7B) ? ubjp_pkg::EvObjOpen : ubjp_pkg::EvListOpen;
              ph_d = (b == 8'h7B) ? ubjp_pkg::PhKey : ubjp_pkg::PhValue;
            end
          end else err_d = 1'b1;
        end
        ubjp_pkg::PhStrMark: begin
          if (isz != 4'd0) begin
            nleft_d = isz; kind_d = ubjp_pkg::KindStrLen;
            sfirst_d = (b != 8'h55); acc_d = '0; ph_d = ubjp_pkg::PhNumber;
          end else err_d = 1'b1;
        end
        ubjp_pkg::PhNumber: begin
          na = sfirst_q ? {{56{b[7]}}, b} : {acc_q[55:0], b};
          sfirst_d = 1'b0; acc_d = na;
          nl = (nleft_q != 4'd0) ? nleft_q - 4'd1 : 4'd0;
          nleft_d = nl;
          if (nl == 4'd0) begin
            if (kind_q == ubjp_pkg::KindInt || kind_q == ubjp_pkg::KindDbl) begin
              ev = (kind_q == ubjp_pkg::KindInt) ? ubjp_pkg::EvInt : ubjp_pkg::EvDbl;
              val = na;
            end else if (na[63]) err_d = 1'b1;
            else begin
              ev = (kind_q == ubjp_pkg::KindKeyLen) ? ubjp_pkg::EvKeyLen
                                                     : ubjp_pkg::EvStrLen;
              val = na; txt_d = na;
              if (na != '0) ph_d = ubjp_pkg::PhText;
              else if (kind_q == ubjp_pkg::KindKeyLen) begin
                pend_d = 1'b1; ph_d = ubjp_pkg::PhValue;
              end
            end
          end
        end
        ubjp_pkg::PhText: begin
          ev = (kind_q == ubjp_pkg::KindKeyLen) ? ubjp_pkg::EvKeyByte
                                                 : ubjp_pkg::EvStrByte;
          val = {56'd0, b};
          txt_d = (txt_q != '0) ? txt_q - 64'd1 : '0;
          if (txt_d == '0 && kind_q == ubjp_pkg::KindKeyLen) begin
            pend_d = 1'b1; ph_d = ubjp_pkg::PhValue;
          end
        end
        default: err_d = 1'b1;
      endcase
      // A finished value returns to the enclosing container.
      if (!err_d && (ev == ubjp_pkg::EvObjClose || ev == ubjp_pkg::EvListClose ||
          ev == ubjp_pkg::EvNull || ev == ubjp_pkg::EvTrue || ev == ubjp_pkg::EvFalse ||
          ev == ubjp_pkg::EvInt || ev == ubjp_pkg::EvDbl ||
          (ev == ubjp_pkg::EvStrLen && val == '0) ||
          (ev == ubjp_pkg::EvStrByte && txt_d == '0))) begin
        pend_d = 1'b0;
        if (cnt_d == '0 || cnt_d > CW'(MD)) ph_d = ubjp_pkg::PhDone;
        else begin
          top_kind = kinds_q[IW'(cnt_d - CW'(1))];
          ph_d = top_kind ? ubjp_pkg::PhValue : ubjp_pkg::PhKey;
        end
      end
      if (err_d) begin
        ev = ubjp_pkg::EvNone; val = '0;
      end
    end
    if (s_tlast_i) st = (!err_d && ph_d == ubjp_pkg::PhDone) ? ubjp_pkg::StOk
                                                             : ubjp_pkg::StErr;
    else st = err_d ? ubjp_pkg::StErr : ubjp_pkg::StBusy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kinds_q <= '0; cnt_q <= '0; ph_q <= ubjp_pkg::PhStart; pend_q <= 1'b0;
      sfirst_q <= 1'b0; err_q <= 1'b0; acc_q <= '0; txt_q <= '0;
      nleft_q <= '0; kind_q <= ubjp_pkg::KindInt; vld_q <= 1'b0;
    end else begin
      if (acc_in) begin
        if (s_tlast_i) begin
          cnt_q <= '0; ph_q <= ubjp_pkg::PhStart; pend_q <= 1'b0;
          sfirst_q <= 1'b0; err_q <= 1'b0; acc_q <= '0; txt_q <= '0;
          nleft_q <= '0; kind_q <= ubjp_pkg::KindInt;
        end else begin
          cnt_q <= cnt_d; ph_q <= ph_d; pend_q <= pend_d; sfirst_q <= sfirst_d;
          err_q <= err_d; acc_q <= acc_d; txt_q <= txt_d; nleft_q <= nleft_d;
          kind_q <= kind_d;
        end
        kinds_q <= kinds_d;
        vld_q <= 1'b1;
      end else if (m_tready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      out_q <= {4'd0, st, 6'(cnt_d), val, ev};
    end
  end
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for ubjson_stream_parser: drives UBJSON documents
// byte by byte and compares each token word with an in-bench parser model.
// Depends on ubjp_pkg and ubjson_stream_parser.
`timescale 1ns / 100ps
module testbench;
  localparam int IdleMax = 18;
  localparam int WatchLimit = 2000;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  depth;
    logic [63:0] value;
    logic [3:0]  event_code;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i = '0;
  logic        s_tlast_i = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [79:0] m_tdata_o;

  ubjson_stream_parser dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser model state.
  logic              kinds_q [ubjp_pkg::MaxDepth];
  int unsigned       opened;
  ubjp_pkg::phase_e  phase;
  logic              pending;
  logic [63:0]       acc;
  int unsigned       nbytes;
  ubjp_pkg::kind_e   purpose;
  logic              sign_first;
  logic [63:0]       text_left;
  logic              err;

  token_t expected_tokens[$];
  int     fail_count = 0;
  int     watch = 0;
  bit     stim_done = 0;

  task automatic clear_model();
    opened = 0; phase = ubjp_pkg::PhStart; pending = 0; acc = '0; nbytes = 0;
    purpose = ubjp_pkg::KindInt; sign_first = 0; text_left = '0; err = 0;
  endtask

  function automatic int unsigned marker_size(logic [7:0] m);
    case (m)
      "i", "U": return 1;
      "I": return 2;
      "l": return 4;
      "L": return 8;
      default: return 0;
    endcase
  endfunction

  task automatic begin_number(logic [7:0] m, ubjp_pkg::kind_e k);
    nbytes = marker_size(m);
    purpose = k;
    sign_first = (m != "U");
    acc = '0;
    phase = ubjp_pkg::PhNumber;
  endtask

  task automatic close_value();
    pending = 0;
    if (opened == 0 || opened > ubjp_pkg::MaxDepth) phase = ubjp_pkg::PhDone;
    else if (kinds_q[opened-1]) phase = ubjp_pkg::PhValue;
    else phase = ubjp_pkg::PhKey;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eod, output token_t t);
    logic [3:0]  ev;
    logic [63:0] val;
    ev = ubjp_pkg::EvNone;
    val = '0;
    if (!err) begin
      case (phase)
        ubjp_pkg::PhStart: begin
          if (b == "{") begin
            kinds_q[0] = 0; opened = 1; ev = ubjp_pkg::EvObjOpen;
            phase = ubjp_pkg::PhFirstKey;
          end else err = 1;
        end
        ubjp_pkg::PhFirstKey, ubjp_pkg::PhKey: begin
          if (marker_size(b) != 0) begin
            begin_number(b, ubjp_pkg::KindKeyLen);
          end else if (b == "}" && phase == ubjp_pkg::PhKey) begin
            opened--; ev = ubjp_pkg::EvObjClose; close_value();
          end else err = 1;
        end
        ubjp_pkg::PhValue: begin
          if (b == "]" && !pending) begin
            opened--; ev = ubjp_pkg::EvListClose; close_value();
          end else if (b == "Z" || b == "T" || b == "F") begin
            ev = (b == "Z") ? ubjp_pkg::EvNull :
                 (b == "T") ? ubjp_pkg::EvTrue : ubjp_pkg::EvFalse;
            close_value();
          end else if (marker_size(b) != 0) begin
            begin_number(b, ubjp_pkg::KindInt);
          end else if (b == "D") begin
            begin_number("L", ubjp_pkg::KindDbl);
          end else if (b == "S") begin
            phase = ubjp_pkg::PhStrMark;
          end else if (b == "{" || b == "[") begin
            if (opened >= ubjp_pkg::MaxDepth) err = 1;
            else begin
              kinds_q[opened] = (b == "[");
              opened++;
              pending = 0;
              ev = (b == "{") ? ubjp_pkg::EvObjOpen : ubjp_pkg::EvListOpen;
              phase = (b == "{") ? ubjp_pkg::PhKey : ubjp_pkg::PhValue;
            end
          end else err = 1;
        end
        ubjp_pkg::PhStrMark: begin
          if (marker_size(b) != 0) begin_number(b, ubjp_pkg::KindStrLen);
          else err = 1;
        end
        ubjp_pkg::PhNumber: begin
          if (sign_first) begin
            acc = {{56{b[7]}}, b};
            sign_first = 0;
          end else acc = {acc[55:0], b};
          if (nbytes > 0) nbytes--;
          if (nbytes == 0) begin
            if (purpose == ubjp_pkg::KindInt || purpose == ubjp_pkg::KindDbl) begin
              ev = (purpose == ubjp_pkg::KindInt) ? ubjp_pkg::EvInt : ubjp_pkg::EvDbl;
              val = acc;
              close_value();
            end else if (acc[63]) err = 1;
            else begin
              ev = (purpose == ubjp_pkg::KindKeyLen) ? ubjp_pkg::EvKeyLen
                                                     : ubjp_pkg::EvStrLen;
              val = acc;
              text_left = acc;
              if (text_left != 0) phase = ubjp_pkg::PhText;
              else if (purpose == ubjp_pkg::KindKeyLen) begin
                pending = 1; phase = ubjp_pkg::PhValue;
              end else close_value();
            end
          end
        end
        ubjp_pkg::PhText: begin
          ev = (purpose == ubjp_pkg::KindKeyLen) ? ubjp_pkg::EvKeyByte
                                                 : ubjp_pkg::EvStrByte;
          val = {56'd0, b};
          if (text_left > 0) text_left--;
          if (text_left == 0) begin
            if (purpose == ubjp_pkg::KindKeyLen) begin
              pending = 1; phase = ubjp_pkg::PhValue;
            end else close_value();
          end
        end
        default: err = 1;
      endcase
      if (err) begin
        ev = ubjp_pkg::EvNone; val = '0;
      end
    end
    t.event_code = ev;
    t.value = val;
    t.depth = opened[5:0];
    if (eod) begin
      t.status = (!err && phase == ubjp_pkg::PhDone) ? ubjp_pkg::StOk : ubjp_pkg::StErr;
      clear_model();
    end else t.status = err ? ubjp_pkg::StErr : ubjp_pkg::StBusy;
  endtask

  // Holds the byte until it is taken, then idles for a random number of cycles.
  task automatic send_byte(input logic [7:0] b, input logic eod = 0);
    token_t t;
    int idle;
    s_tvalid_i <= 1'b1;
    s_tdata_i <= b;
    s_tlast_i <= eod;
    do @(posedge clk_i); while (!s_tready_o);
    parse_byte(b, eod, t);
    expected_tokens = {expected_tokens, t};
    idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IdleMax);
    if (idle > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  task automatic send_seq(input logic [7:0] bytes[$], input bit eod_last = 1);
    foreach (bytes[k]) send_byte(bytes[k], eod_last && k == bytes.size() - 1);
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Sink side: random stalls, compares each word with the oldest prediction.
  initial begin
    token_t got, want;
    int stall;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IdleMax);
      if (stall > 0) begin
        m_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      got = m_tdata_o[75:0];
      if (expected_tokens.size() == 0) begin
        $display("%0t: word expected none actual %h", $time, got);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (got.event_code !== want.event_code) begin
          $display("%0t: event expected %0d actual %0d", $time, want.event_code,
                   got.event_code);
          fail_count++;
        end
        if (got.value !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, got.value);
          fail_count++;
        end
        if (got.depth !== want.depth) begin
          $display("%0t: depth expected %0d actual %0d", $time, want.depth, got.depth);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   got.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) || stim_done) watch <= 0;
    else watch <= watch + 1;
    if (watch >= WatchLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] x);
    q = {q, x};
  endfunction

  // Random well-formed value, occasionally nested, with random content.
  function automatic void gen_int(ref logic [7:0] q[$], input logic [7:0] m);
    repeat (marker_size(m)) add_byte(q, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void gen_len(ref logic [7:0] q[$], input int n);
    add_byte(q, "U"); add_byte(q, n[7:0]);
    repeat (n) add_byte(q, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void gen_value(ref logic [7:0] q[$], input int lvl);
    logic [7:0] ints[5] = '{"i", "U", "I", "l", "L"};
    int n;
    case ($urandom_range(0, 7))
      0: add_byte(q, "Z");
      1: add_byte(q, $urandom_range(0, 1) ? "T" : "F");
      2: begin add_byte(q, ints[$urandom_range(0, 4)]); gen_int(q, q[$]); end
      3: begin add_byte(q, "D"); gen_int(q, "L"); end
      4: begin add_byte(q, "S"); gen_len(q, $urandom_range(0, 4)); end
      5: if (lvl < 3) begin
        add_byte(q, "["); n = $urandom_range(0, 3);
        repeat (n) gen_value(q, lvl + 1);
        add_byte(q, "]");
      end else add_byte(q, "Z");
      default: if (lvl < 3) gen_object(q, lvl + 1); else add_byte(q, "T");
    endcase
  endfunction

  function automatic void gen_object(ref logic [7:0] q[$], input int lvl);
    int n;
    add_byte(q, "{");
    n = (lvl == 0) ? $urandom_range(1, 3) : $urandom_range(0, 2);
    repeat (n) begin
      gen_len(q, $urandom_range(0, 3));
      gen_value(q, lvl);
    end
    add_byte(q, "}");
  endfunction

  task automatic test_scalars();
    send_seq('{"{", "U", 8'd1, "a", "Z", "i", 8'd0, "T", "U", 8'd0, "F", "}"});
    send_seq('{"{", "i", 8'd0, "i", 8'h80, "U", 8'd0, "U", 8'hFF, "}"});
    send_seq('{"{", "i", 8'd0, "L", 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               8'hFF, "}"});
    send_seq('{"{", "i", 8'd0, "D", 8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
               8'h00, 8'h00, "}"});
    send_seq('{"{", "i", 8'd0, "S", "I", 8'h00, 8'h02, 8'hFF, 8'h00, "}"});
  endtask

  task automatic test_containers();
    send_seq('{"{", "i", 8'd0, "[", "l", 8'hFF, 8'hFF, 8'hFF, 8'hFE, "[", "]", "]",
               "i", 8'd0, "{", "}", "}"});
  endtask

  task automatic test_errors();
    send_seq('{"{", "}"});                               // empty top-level object
    send_seq('{"A", "{"});                               // bad first byte
    send_seq('{"{", "i", 8'hFF, "Z", "}"});              // negative key length
    send_seq('{"{", "i", 8'd0, "S", "i", 8'h80, "}"});   // negative string length
    send_seq('{"{", "i", 8'd0, "Z", "}", "Z"});          // trailing byte
    send_seq('{"{", "i", 8'd0, "["});                    // end while still open
    send_seq('{"{", "i", 8'd0, "Z", "]", "}"});          // stray list close
    send_seq('{"{", "i", 8'd0, "]"});                    // close with key pending
  endtask

  task automatic test_overflow();
    logic [7:0] q[$];
    q = '{"{", "i", 8'd0};
    repeat (ubjp_pkg::MaxDepth) add_byte(q, "[");
    send_seq(q);
  endtask

  task automatic test_random_docs();
    logic [7:0] q[$];
    int sent = 0;
    while (sent < 500) begin
      q.delete();
      gen_object(q, 0);
      if ($urandom_range(0, 4) == 0)
        q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) q = q[0:$urandom_range(0, q.size() - 1)];
      if ($urandom_range(0, 9) == 0) add_byte(q, 8'($urandom_range(0, 255)));
      send_seq(q);
      sent += q.size();
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  initial begin
    clear_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_scalars();
    test_containers();
    wait_drained();
    test_errors();
    test_overflow();
    test_random_docs();
    wait_drained();
    stim_done = 1;
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && expected_tokens.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
